// File: design/tgce_pkg.sv
package tgce_pkg;

  // Sizes of the block.
  localparam int STACK_DEPTH   = 64;
  localparam int SINE_ENTRIES  = 256;
  localparam int POS_FRAC_BITS = 8;

  // Field widths.
  localparam int POS_W       = 24;
  localparam int ANGLE_W     = 16;
  localparam int DIST_W      = 16;
  localparam int COLOR_W     = 32;
  localparam int KIND_W      = 3;
  localparam int DEPTH_OUT_W = 7;

  // Derived widths.
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_WIDE_W = CNT_W + DEPTH_OUT_W;
  localparam int ENTRY_W      = ANGLE_W + 2 * POS_W;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES + 1);
  localparam int SCALE_W      = SINE_IDX_W + 14;
  localparam int SINE_W       = 17;
  localparam int TRIG_W       = SINE_W + 1;
  localparam int PROD_W       = TRIG_W + DIST_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int STEP_SHIFT   = 23 - POS_FRAC_BITS;

  // Constants.
  localparam logic [COLOR_W-1:0]      COLOR_RESET  = 32'hFFFF_FFFF;
  localparam logic [ANGLE_W-1:0]      QUARTER_TURN = 16'h4000;
  localparam logic signed [SUM_W-1:0] ROUND_HALF   = SUM_W'(1) <<< (STEP_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] POS_MAX      = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] POS_MIN      = -SUM_W'(8388608);
  localparam logic [63:0]             HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0]             Q30_ONE      = 64'd1 << 30;

  // Command codes as they arrive on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_FORWARD     = 3'd0,
    KIND_TURN_PLUS   = 3'd1,
    KIND_TURN_MINUS  = 3'd2,
    KIND_MOVE_TO     = 3'd3,
    KIND_PUSH        = 3'd4,
    KIND_POP         = 3'd5,
    KIND_SET_HEADING = 3'd6,
    KIND_CLEAR       = 3'd7
  } kind_t;

  // Operations after classification.
  typedef enum logic [2:0] {
    OP_FORWARD,
    OP_TURN,
    OP_SET_HEADING,
    OP_MOVE_TO,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } op_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DIST_W-1:0] distance;
    logic [ANGLE_W-1:0]       angle_value;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
  } cmd_t;

  typedef struct packed {
    logic                    segment_valid;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic [COLOR_W-1:0]      segment_color;
    logic [ANGLE_W-1:0]      heading;
    logic                    stack_fault;
    logic [DEPTH_OUT_W-1:0]  stack_depth;
  } result_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DIST_W-1:0] distance;
    logic [ANGLE_W-1:0]       angle;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
  } op_item_t;

  typedef struct packed {
    logic     valid;
    op_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]      heading;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } stack_entry_t;

  typedef logic [SINE_ENTRIES:0][SINE_W-1:0] sine_rom_t;

  // One quarter-wave entry: Taylor series to x^11 in Q30, rounded to Q15.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    int        i;
    for (i = 0; i <= SINE_ENTRIES; i++) begin
      rom[i] = quarter_sine(32'(i));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Signed 18-bit Q2.15 sine of a binary angle from the quarter-wave table.
  function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [ANGLE_W-1:0] h);
    logic [1:0]               quad;
    logic [SCALE_W-1:0]       scaled;
    logic [SINE_IDX_W-1:0]    idx;
    logic signed [TRIG_W-1:0] mag;
    quad   = h[ANGLE_W-1:ANGLE_W-2];
    scaled = SCALE_W'(h[13:0]) * SCALE_W'(SINE_ENTRIES);
    idx    = scaled[SCALE_W-1:14];
    if (quad[0]) begin
      idx = SINE_IDX_W'(SINE_ENTRIES) - idx;
    end
    mag = $signed({1'b0, SINE_ROM[idx]});
    return quad[1] ? -mag : mag;
  endfunction

endpackage

// File: design/turtle_graphics_command_engine.sv
// An accepted command passes the queue, the fetch state and the execute state, where the result
// register loads on commit. Commands are taken one at a time: fetch (sine table and stack memory
// read) then execute (position update), which waits while a result is stalled. The input side
// keeps accepting into a 2-entry queue, until it is full, while a result waits to be taken.
// Reset is synchronous and active high: position, heading and stack depth clear, the color
// register returns to opaque white, queue and output empty; stack memory is not cleared.
module turtle_graphics_command_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tgce_pkg::cmd_t    cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output tgce_pkg::result_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  import tgce_pkg::*;

  queue_head_t q_head;
  logic        q_pop;

  // Front end: accept and classify commands.
  tgce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  // Back end: carry out commands and hold the turtle state.
  tgce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef ASSERT_OFF
  a_color_only_on_segment: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.segment_valid |-> res.segment_color == '0)
    else $error("segment color set on a beat without a segment");

  a_fault_never_draws: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.stack_fault |-> !res.segment_valid)
    else $error("stack fault reported together with a segment");

  a_reset_empties_output: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res.stack_depth) <= STACK_DEPTH)
    else $error("stack depth beyond stack size");
`endif

endmodule

// File: design/tgce_ram.sv
module tgce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tgce_front.sv
module tgce_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  tgce_pkg::cmd_t        cmd,
  input  logic                  q_pop,
  output tgce_pkg::queue_head_t q_head
);

  import tgce_pkg::*;

  op_item_t   classified;
  op_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       accept;

  // Classify the command; a minus turn becomes a turn by the negated angle.
  always_comb begin
    classified.distance = cmd.distance;
    classified.angle    = cmd.angle_value;
    classified.target_x = cmd.target_x;
    classified.target_y = cmd.target_y;
    unique case (cmd.kind)
      KIND_FORWARD:     classified.op = OP_FORWARD;
      KIND_TURN_PLUS:   classified.op = OP_TURN;
      KIND_TURN_MINUS: begin
        classified.op    = OP_TURN;
        classified.angle = ANGLE_W'(0) - cmd.angle_value;
      end
      KIND_MOVE_TO:     classified.op = OP_MOVE_TO;
      KIND_PUSH:        classified.op = OP_PUSH;
      KIND_POP:         classified.op = OP_POP;
      KIND_SET_HEADING: classified.op = OP_SET_HEADING;
      KIND_CLEAR:       classified.op = OP_CLEAR;
    endcase
  end

  // Two-entry queue toward the execution side.
  assign cmd_stall    = (fill == 2'd2);
  assign accept       = cmd_valid && !cmd_stall;
  assign q_head.valid = (fill != 2'd0);
  assign q_head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (accept && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!accept && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Queue payload holds no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= classified;
    end
  end

endmodule

// File: design/tgce_back.sv
module tgce_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  input  tgce_pkg::queue_head_t q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output tgce_pkg::result_t     res
);

  import tgce_pkg::*;

  back_state_t              state;
  back_state_t              state_next;
  op_item_t                 op;
  logic signed [TRIG_W-1:0] cos_val;
  logic signed [TRIG_W-1:0] sin_val;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_x_next;
  logic signed [POS_W-1:0]  pos_y_next;
  logic [ANGLE_W-1:0]       cur_heading;
  logic [ANGLE_W-1:0]       heading_next;
  logic [CNT_W-1:0]         stack_count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         top_index;
  logic [DEPTH_WIDE_W-1:0]  depth_wide;
  logic [COLOR_W-1:0]       draw_color;
  logic                     fetch;
  logic                     commit;
  logic                     res_free;
  logic                     fault;
  logic                     seg;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [SUM_W-1:0]  step_x;
  logic signed [SUM_W-1:0]  step_y;
  logic signed [SUM_W-1:0]  moved_x;
  logic signed [SUM_W-1:0]  moved_y;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  stack_entry_t             ram_wdata;
  stack_entry_t             popped;
  logic [ENTRY_W-1:0]       ram_rdata;
  result_t                  res_next;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > POS_MAX) begin
      c = POS_MAX;
    end else if (v < POS_MIN) begin
      c = POS_MIN;
    end
    return c[POS_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign res_free  = !res_valid || !res_stall;
  assign q_pop     = fetch;

  // Fetch reads trig values and the stack top; execute updates the state.
  always_comb begin
    state_next = state;
    fetch      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      BK_FETCH: begin
        if (q_head.valid) begin
          fetch      = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (res_free) begin
          commit     = 1'b1;
          state_next = BK_FETCH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FETCH;
    end else begin
      state <= state_next;
    end
  end

  // Stack memory: read the top entry at fetch, write on a committed push that does not overflow.
  assign top_index = stack_count - CNT_W'(1);
  assign ram_raddr = top_index[ADDR_W-1:0];
  assign ram_wdata = '{heading: cur_heading, x: pos_x, y: pos_y};
  assign popped    = stack_entry_t'(ram_rdata);

  tgce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stack_count[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (fetch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand registers loaded at fetch.
  always_ff @(posedge clk) begin
    if (fetch) begin
      op      <= q_head.item;
      cos_val <= sine_lookup(cur_heading + QUARTER_TURN);
      sin_val <= sine_lookup(cur_heading);
    end
  end

  // Forward step: scale, round half up, then saturating add.
  always_comb begin
    prod_x  = cos_val * op.distance;
    prod_y  = sin_val * op.distance;
    step_x  = (SUM_W'(prod_x) + ROUND_HALF) >>> STEP_SHIFT;
    step_y  = (SUM_W'(prod_y) + ROUND_HALF) >>> STEP_SHIFT;
    moved_x = step_x + SUM_W'(pos_x);
    moved_y = step_y + SUM_W'(pos_y);
  end

  // Next turtle state for the operation in execute.
  always_comb begin
    pos_x_next   = pos_x;
    pos_y_next   = pos_y;
    heading_next = cur_heading;
    count_next   = stack_count;
    fault        = 1'b0;
    seg          = 1'b0;
    ram_we       = 1'b0;
    unique case (op.op)
      OP_FORWARD: begin
        pos_x_next = sat_pos(moved_x);
        pos_y_next = sat_pos(moved_y);
        seg        = 1'b1;
      end
      OP_TURN:        heading_next = cur_heading + op.angle;
      OP_SET_HEADING: heading_next = op.angle;
      OP_MOVE_TO: begin
        pos_x_next = op.target_x;
        pos_y_next = op.target_y;
      end
      OP_PUSH: begin
        if (stack_count == CNT_W'(STACK_DEPTH)) begin
          fault = 1'b1;
        end else begin
          ram_we     = commit;
          count_next = stack_count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (stack_count == CNT_W'(0)) begin
          fault = 1'b1;
        end else begin
          count_next   = top_index;
          heading_next = popped.heading;
          pos_x_next   = popped.x;
          pos_y_next   = popped.y;
        end
      end
      OP_CLEAR: begin
        pos_x_next   = '0;
        pos_y_next   = '0;
        heading_next = '0;
        count_next   = '0;
      end
      default: begin
        fault = 1'b0;
      end
    endcase
  end

  // Result beat assembled from the old and new state.
  always_comb begin
    depth_wide             = DEPTH_WIDE_W'(count_next);
    res_next.segment_valid = seg;
    res_next.start_x       = pos_x;
    res_next.start_y       = pos_y;
    res_next.end_x         = pos_x_next;
    res_next.end_y         = pos_y_next;
    res_next.segment_color = seg ? draw_color : '0;
    res_next.heading       = heading_next;
    res_next.stack_fault   = fault;
    res_next.stack_depth   = depth_wide[DEPTH_OUT_W-1:0];
  end

  // Turtle state, color register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      cur_heading <= '0;
      stack_count <= '0;
      draw_color  <= COLOR_RESET;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        draw_color <= cfg_data;
      end
      if (commit) begin
        pos_x       <= pos_x_next;
        pos_y       <= pos_y_next;
        cur_heading <= heading_next;
        stack_count <= count_next;
        res_valid   <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (commit) begin
      res <= res_next;
    end
  end

endmodule
